// ===== rtl/vdlp_pkg.sv =====
// shared types, opcodes and helper functions for the vector display list processor
// no dependencies; compiled before the interfaces and the top level
package vdlp_pkg;

  localparam int STACK_DEPTH_DEF = 4;
  localparam logic [31:0] CENTER_RESET = 32'h0200_0000;
  localparam int PADDR_W = 3;

  localparam logic [2:0] OP_VCTR = 3'd0;
  localparam logic [2:0] OP_HALT = 3'd1;
  localparam logic [2:0] OP_SVEC = 3'd2;
  localparam logic [2:0] OP_STAT = 3'd3;
  localparam logic [2:0] OP_CNTR = 3'd4;
  localparam logic [2:0] OP_JSRL = 3'd5;
  localparam logic [2:0] OP_RTSL = 3'd6;
  localparam logic [2:0] OP_JMPL = 3'd7;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_BYTE  = 1'b1;

  localparam logic REG_CENTER_X = 1'b0;
  localparam logic REG_CENTER_Y = 1'b1;

  localparam logic [15:0] TIMER_FULL = 16'h8000;
  localparam logic [15:0] TIMER_SHORT = 16'h0100;
  localparam logic [15:0] PARK_CYCLES = 16'd8;
  localparam logic [15:0] FETCH_CYCLES = 16'd8;

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_SCALE, S_CNTR, S_EXEC,
    S_MULX1, S_MULX2, S_MULY1, S_MULY2, S_BRIGHT, S_OUT
  } state_t;

  // one step of the beam timer
  function automatic logic [14:0] timer_shift(input logic [14:0] t, input logic svec);
    logic [14:0] s;
    s = {1'b1, t[14:1]};
    s[7] = s[7] | svec;
    return s;
  endfunction

  // fixed sequencer cost of each instruction
  function automatic logic [15:0] exec_cycles(input logic [2:0] op);
    logic [15:0] c;
    unique case (op)
      OP_VCTR, OP_SVEC: c = 16'd32;
      OP_HALT:          c = 16'd8;
      OP_STAT:          c = 16'd40;
      OP_CNTR, OP_JSRL: c = 16'd24;
      OP_RTSL:          c = 16'd16;
      OP_JMPL:          c = 16'd8;
      default:          c = 16'd8;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/vdlp_item_if.sv =====
// input and result channel interfaces for the vector display list processor
// no dependencies beyond the handshake itself
interface vdlp_item_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] byte_value;
  modport source (output valid, req_type, byte_value, input ready);
  modport sink (input valid, req_type, byte_value, output ready);
endinterface

interface vdlp_result_if;
  logic               valid;
  logic               ready;
  logic [15:0]        fetch_address;
  logic               point_valid;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic [3:0]         point_color;
  logic [7:0]         point_bright;
  logic               is_halted;
  logic [15:0]        spent_cycles;
  modport source (output valid, fetch_address, point_valid, point_x, point_y, point_color,
                  point_bright, is_halted, spent_cycles, input ready);
  modport sink (input valid, fetch_address, point_valid, point_x, point_y, point_color,
                point_bright, is_halted, spent_cycles, output ready);
endinterface

// ===== rtl/vector_display_list_processor.sv =====
// vector display list processor: one byte word in, one result word out
// a byte that completes nothing goes straight to S_OUT, a control instruction passes S_EXEC,
// a center S_NORM and S_CNTR, a vector S_NORM, S_SCALE, S_MULX1 to S_MULY2 and S_BRIGHT;
// normalize does up to 16 steps, scale up to 7, and 4 passes go through one shared multiplier
// one word at a time: ready again the cycle after the result is taken
// reset (rst, synchronous, active high) halts the processor; centers go to 0x02000000
// depends on vdlp_pkg and the channel interfaces
module vector_display_list_processor #(
  parameter int STACK_DEPTH = vdlp_pkg::STACK_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  vdlp_item_if.sink                     item,
  vdlp_result_if.source                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vdlp_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import vdlp_pkg::*;

  localparam int SP_IDX_W = $clog2(STACK_DEPTH);

  state_t state, state_next;

  logic [31:0] center_x, center_y;
  logic [2:0]  byte_phase, opcode;
  logic [12:0] delta_y, delta_x;
  logic        ydelta_top_bit;
  logic [3:0]  intensity_latch;
  logic [14:0] beam_timer;
  logic [7:0]  linear_scale;
  logic [2:0]  binary_scale;
  logic [7:0]  beam_level;
  logic [3:0]  beam_color;
  logic [3:0]  stack_pointer;
  logic [15:0] return_stack [STACK_DEPTH];
  logic [15:0] program_counter;
  logic [31:0] beam_x, beam_y;
  logic        halt_flag, parked;
  logic [4:0]  norm_cnt;
  logic [2:0]  scale_cnt;
  logic [15:0] move_cycles;
  logic signed [35:0] mul_p;

  logic               point_valid;
  logic [31:0]        point_x, point_y;
  logic [3:0]         point_color;
  logic [7:0]         point_bright;
  logic [15:0]        spent_cycles;

  // byte decode
  logic [2:0]  lat_op, lat_phase;
  logic [12:0] lat_dy, lat_dx;
  logic [3:0]  lat_il;
  logic        lat_top, lat_done;
  logic        accept;
  logic [7:0]  d;

  assign accept = item.valid && item.ready;
  assign d = item.byte_value;

  always_comb begin
    lat_op = opcode;
    lat_top = ydelta_top_bit;
    lat_il = intensity_latch;
    lat_dy = delta_y;
    lat_dx = delta_x;
    lat_phase = byte_phase;
    lat_done = 1'b0;
    if (byte_phase == 3'd0) begin
      lat_top = d[4];
      lat_op = d[7:5];
      lat_il = 4'd0;
      lat_dy = {d[4], d[3:0], 8'h00};
      lat_dx = 13'd0;
      lat_phase = 3'd1;
    end else if (opcode == OP_SVEC || (opcode == OP_VCTR && byte_phase == 3'd2)) begin
      lat_il = d[7:4];
      lat_dx = {d[4], d[3:0], delta_x[7:0]};
      lat_phase = byte_phase + 3'd1;
      lat_done = (opcode == OP_SVEC);
    end else if (opcode == OP_VCTR && byte_phase == 3'd3) begin
      lat_dx = {delta_x[12:8], d};
      lat_done = 1'b1;
    end else begin
      lat_dy = {delta_y[12:8], d};
      lat_phase = byte_phase + 3'd1;
      lat_done = (opcode != OP_VCTR);
    end
    if (lat_done) begin
      lat_phase = 3'd0;
    end
  end

  logic norm_go;
  assign norm_go = (delta_y[12] == delta_y[11]) && (delta_x[12] == delta_x[11])
                   && (norm_cnt < 5'd16);

  // shared multiplier
  logic signed [26:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [43:0] mul_prod;
  always_comb begin
    unique case (state)
      S_MULX1: begin
        mul_a = 27'($signed(delta_x[12:3]));
        mul_b = $signed({1'b0, move_cycles});
      end
      S_MULY1: begin
        mul_a = 27'($signed(delta_y[12:3]));
        mul_b = $signed({1'b0, move_cycles});
      end
      default: begin
        mul_a = mul_p[26:0];
        mul_b = $signed({9'd0, ~linear_scale});
      end
    endcase
    mul_prod = mul_a * mul_b;
  end

  logic [8:0]  dac;
  logic [16:0] lv_sum;
  always_comb begin
    dac = (intensity_latch[3] ? 9'd146 : 9'd0) + (intensity_latch[2] ? 9'd73 : 9'd0)
        + (intensity_latch[1] ? 9'd37 : 9'd0);
    lv_sum = {8'd0, dac} * {9'd0, beam_level} + 17'd128;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (item.req_type == REQ_START || halt_flag || !lat_done) begin
            state_next = S_OUT;
          end else if (lat_op == OP_VCTR || lat_op == OP_SVEC || lat_op == OP_CNTR) begin
            state_next = S_NORM;
          end else begin
            state_next = S_EXEC;
          end
        end
      end
      S_NORM:   if (!norm_go) state_next = (opcode == OP_CNTR) ? S_CNTR : S_SCALE;
      S_SCALE:  if (scale_cnt == 3'd0) state_next = S_MULX1;
      S_CNTR:   state_next = S_OUT;
      S_EXEC:   state_next = S_OUT;
      S_MULX1:  state_next = S_MULX2;
      S_MULX2:  state_next = S_MULY1;
      S_MULY1:  state_next = S_MULY2;
      S_MULY2:  state_next = S_BRIGHT;
      S_BRIGHT: state_next = S_OUT;
      S_OUT:    if (result.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= CENTER_RESET;
      center_y <= CENTER_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_CENTER_Y) begin
        center_y <= pwdata;
      end else begin
        center_x <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == REG_CENTER_Y) ? center_y : center_x;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase <= '0; opcode <= '0; delta_y <= '0; delta_x <= '0;
      ydelta_top_bit <= 1'b0; intensity_latch <= '0; beam_timer <= '0;
      linear_scale <= '0; binary_scale <= '0; beam_level <= '0; beam_color <= '0;
      stack_pointer <= '0; program_counter <= '0; beam_x <= '0; beam_y <= '0;
      halt_flag <= 1'b1; parked <= 1'b0;
      for (int i = 0; i < STACK_DEPTH; i++) return_stack[i] <= '0;
      norm_cnt <= '0; scale_cnt <= '0; move_cycles <= '0; mul_p <= '0;
      point_valid <= 1'b0; point_x <= '0; point_y <= '0; point_color <= '0;
      point_bright <= '0; spent_cycles <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            point_valid <= 1'b0; point_x <= '0; point_y <= '0;
            point_color <= '0; point_bright <= '0;
            norm_cnt <= '0;
            if (item.req_type == REQ_START) begin
              spent_cycles <= parked ? PARK_CYCLES : 16'd0;
              parked <= 1'b0;
              program_counter <= '0; stack_pointer <= '0;
              halt_flag <= 1'b0; byte_phase <= '0;
            end else if (halt_flag) begin
              spent_cycles <= '0;
            end else begin
              opcode <= lat_op; ydelta_top_bit <= lat_top; intensity_latch <= lat_il;
              delta_y <= lat_dy; delta_x <= lat_dx; byte_phase <= lat_phase;
              program_counter <= program_counter + 16'd1;
              spent_cycles <= FETCH_CYCLES + (lat_done ? exec_cycles(lat_op) : 16'd0);
            end
          end
        end
        S_NORM: begin
          if (norm_go) begin
            delta_y <= {delta_y[12], delta_y[10:0], 1'b0};
            delta_x <= {delta_x[12], delta_x[10:0], 1'b0};
            beam_timer <= timer_shift(beam_timer, opcode[1]);
            norm_cnt <= norm_cnt + 5'd1;
          end else begin
            if (opcode == OP_SVEC) beam_timer <= {7'd0, beam_timer[7:0]};
            scale_cnt <= binary_scale;
          end
        end
        S_SCALE: begin
          if (scale_cnt != 3'd0) begin
            beam_timer <= timer_shift(beam_timer, opcode[1]);
            scale_cnt <= scale_cnt - 3'd1;
          end else begin
            if (opcode == OP_SVEC) begin
              move_cycles <= TIMER_SHORT - {8'd0, beam_timer[7:0]};
            end else begin
              move_cycles <= TIMER_FULL - {1'b0, beam_timer};
            end
            beam_timer <= '0;
          end
        end
        S_CNTR: begin
          spent_cycles <= spent_cycles + (TIMER_FULL - {1'b0, beam_timer});
          beam_timer <= '0;
          beam_x <= center_x; beam_y <= center_y;
          point_valid <= 1'b1; point_x <= center_x; point_y <= center_y;
          halt_flag <= 1'b0;
        end
        S_EXEC: begin
          unique case (opcode)
            OP_HALT: begin
              halt_flag <= 1'b1;
              parked <= 1'b1;
            end
            OP_STAT: begin
              if (!ydelta_top_bit) begin
                beam_level <= delta_y[7:0];
                beam_color <= delta_y[11:8];
              end else begin
                linear_scale <= delta_y[7:0];
                binary_scale <= delta_y[10:8];
              end
            end
            OP_JSRL: begin
              return_stack[stack_pointer[SP_IDX_W-1:0]] <= program_counter;
              stack_pointer <= stack_pointer + 4'd1;
              program_counter <= {2'b00, delta_y, 1'b0};
            end
            OP_RTSL: begin
              stack_pointer <= stack_pointer - 4'd1;
              program_counter <= return_stack[SP_IDX_W'(stack_pointer - 4'd1)];
            end
            default: begin
              program_counter <= {2'b00, delta_y, 1'b0};
            end
          endcase
        end
        S_MULX1: begin
          spent_cycles <= spent_cycles + move_cycles;
          mul_p <= mul_prod[35:0];
        end
        S_MULX2: mul_p <= mul_prod[35:0];
        S_MULY1: begin
          beam_x <= beam_x + 32'(mul_p[35:4]);
          mul_p <= mul_prod[35:0];
        end
        S_MULY2: mul_p <= mul_prod[35:0];
        S_BRIGHT: begin
          beam_y <= beam_y - 32'(mul_p[35:4]);
          point_valid <= 1'b1;
          point_x <= beam_x;
          point_y <= beam_y - 32'(mul_p[35:4]);
          point_color <= beam_color;
          point_bright <= (lv_sum[16:8] > 9'd255) ? 8'hff : lv_sum[15:8];
          halt_flag <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign item.ready = (state == S_IDLE);
  assign result.valid = (state == S_OUT);
  assign result.fetch_address = program_counter;
  assign result.point_valid = point_valid;
  assign result.point_x = point_x;
  assign result.point_y = point_y;
  assign result.point_color = point_color;
  assign result.point_bright = point_bright;
  assign result.is_halted = halt_flag;
  assign result.spent_cycles = spent_cycles;

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for vector_display_list_processor: byte words in, results out
// depends on vdlp_pkg, the channel interfaces and the top level under rtl
`timescale 1ns / 1ps

module testbench;
  import vdlp_pkg::*;

  typedef struct packed {
    logic [15:0] fetch_address;
    logic        point_valid;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [3:0]  point_color;
    logic [7:0]  point_bright;
    logic        is_halted;
    logic [15:0] spent_cycles;
  } list_result_t;

  class list_scoreboard;
    logic [31:0] ctr_x, ctr_y;
    logic [2:0]  phase, op;
    logic [12:0] dy, dx;
    logic        ytop, halted, parked;
    logic [3:0]  inten, color, sp;
    logic [14:0] timer;
    logic [7:0]  lin_scale, level;
    logic [2:0]  exp_scale;
    logic [15:0] pc;
    logic [15:0] ret_stack[4];
    logic [31:0] bx, by;
    list_result_t pt;
    list_result_t pending_results[$];
    int errors;

    function new();
      ctr_x = CENTER_RESET; ctr_y = CENTER_RESET;
      phase = 0; op = 0; dy = 0; dx = 0; ytop = 0; inten = 0; timer = 0;
      lin_scale = 0; exp_scale = 0; level = 0; color = 0; sp = 0; pc = 0;
      foreach (ret_stack[i]) ret_stack[i] = 0;
      bx = 0; by = 0; halted = 1; parked = 0; errors = 0;
    endfunction

    function void tick_timer();
      timer = {1'b1, timer[14:1]} | (15'(op[1]) << 7);
    endfunction

    function logic [31:0] beam_step(logic [12:0] d, int unsigned cyc);
      longint dac, p;
      dac = longint'($signed(d[12:3]));
      p = dac * longint'(cyc) * longint'(lin_scale ^ 8'hff);
      p = p >>> 4;
      return p[31:0];
    endfunction

    function void strobe_norm();
      if (op[0]) begin
        ret_stack[sp[1:0]] = pc;
      end else begin
        for (int n = 0; n < 16 && dy[12] == dy[11] && dx[12] == dx[11]; n++) begin
          dy = {dy[12], dy[10:0], 1'b0};
          dx = {dx[12], dx[10:0], 1'b0};
          tick_timer();
        end
        if (op[1]) timer &= 15'h00ff;
      end
    endfunction

    function void strobe_scale();
      if (!op[2]) begin
        repeat (exp_scale) tick_timer();
        if (op[1]) timer &= 15'h00ff;
      end else if (op[1]) begin
        sp = sp - 1;
      end else begin
        sp = sp + 1;
      end
    endfunction

    function void strobe_load();
      if (!op[2] && !ytop) begin
        level = dy[7:0];
        color = dy[11:8];
      end
      if (op[2]) begin
        if (op[0]) pc = 16'(dy) << 1;
        else pc = ret_stack[sp[1:0]];
      end else if (ytop) begin
        lin_scale = dy[7:0];
        exp_scale = dy[10:8];
      end
    endfunction

    function int unsigned strobe_move();
      int unsigned cyc, dac, lv;
      cyc = 0;
      halted = op[0];
      if (!op[0] && !op[2]) begin
        cyc = op[1] ? 256 - timer[7:0] : 32768 - timer;
        timer = 0;
        bx = bx + beam_step(dx, cyc);
        by = by - beam_step(dy, cyc);
        dac = inten[3] * 146 + inten[2] * 73 + inten[1] * 37;
        lv = (dac * level + 128) >> 8;
        if (lv > 255) lv = 255;
        pt.point_valid = 1; pt.point_x = bx; pt.point_y = by;
        pt.point_color = color; pt.point_bright = lv[7:0];
      end
      if (op[2]) begin
        cyc = 32768 - timer;
        timer = 0;
        bx = ctr_x; by = ctr_y;
        pt.point_valid = 1; pt.point_x = bx; pt.point_y = by;
        pt.point_color = 0; pt.point_bright = 0;
      end
      return cyc;
    endfunction

    function int unsigned run_instruction();
      case (op)
        OP_VCTR, OP_SVEC: begin strobe_norm(); strobe_scale(); return 32 + strobe_move(); end
        OP_HALT: return 8 + strobe_move();
        OP_STAT: begin strobe_load(); return 40; end
        OP_CNTR: begin strobe_norm(); return 24 + strobe_move(); end
        OP_JSRL: begin strobe_norm(); strobe_scale(); strobe_load(); return 24; end
        OP_RTSL: begin strobe_scale(); strobe_load(); return 16; end
        default: begin strobe_load(); return 8; end
      endcase
    endfunction

    function void set_center(logic idx, logic [31:0] v);
      if (idx == REG_CENTER_X) ctr_x = v;
      else ctr_y = v;
    endfunction

    function void note_input(logic rt, logic [7:0] d);
      int unsigned cyc;
      logic done;
      cyc = 0;
      pt = '0;
      if (rt == REQ_START) begin
        if (parked) cyc = 8;
        parked = 0; pc = 0; sp = 0; halted = 0; phase = 0;
      end else if (!halted) begin
        done = 0;
        cyc = 8;
        if (phase == 0) begin
          ytop = d[4];
          op = d[7:5];
          inten = 0;
          dy = {ytop, d[3:0], 8'h00};
          dx = 0;
          phase = 1;
        end else if (op == OP_SVEC || (op == OP_VCTR && phase == 2)) begin
          inten = d[7:4];
          dx = {inten[0], d[3:0], dx[7:0]};
          phase++;
          done = (op == OP_SVEC);
        end else if (op == OP_VCTR && phase == 3) begin
          dx = {dx[12:8], d};
          done = 1;
        end else begin
          dy = {dy[12:8], d};
          phase++;
          done = (op != OP_VCTR);
        end
        pc = pc + 1;
        if (done) begin
          phase = 0;
          cyc += run_instruction();
          if (halted) parked = 1;
        end
      end
      if (cyc > 16'hffff) cyc = 16'hffff;
      pt.fetch_address = pc;
      pt.is_halted = halted;
      pt.spent_cycles = cyc[15:0];
      pending_results.push_back(pt);
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
      end
    endfunction

    function void check_result(list_result_t got);
      list_result_t e;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none actual %h", $time, got);
        return;
      end
      e = pending_results.pop_front();
      cmp("fetch_address", e.fetch_address, got.fetch_address);
      cmp("point_valid", e.point_valid, got.point_valid);
      cmp("point_x", e.point_x, got.point_x);
      cmp("point_y", e.point_y, got.point_y);
      cmp("point_color", e.point_color, got.point_color);
      cmp("point_bright", e.point_bright, got.point_bright);
      cmp("is_halted", e.is_halted, got.is_halted);
      cmp("spent_cycles", e.spent_cycles, got.spent_cycles);
    endfunction
  endclass

  logic clk = 0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  vdlp_item_if item_ch();
  vdlp_result_if result_ch();
  list_scoreboard sb = new();
  bit gaps_on = 1;
  int stall_left = 0;
  int words_sent = 0;

  vector_display_list_processor dut (
    .clk(clk), .rst(rst), .item(item_ch.sink), .result(result_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // result side: check on handshake, stall in bursts
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready)
        sb.check_result({result_ch.fetch_address, result_ch.point_valid, result_ch.point_x,
                         result_ch.point_y, result_ch.point_color, result_ch.point_bright,
                         result_ch.is_halted, result_ch.spent_cycles});
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 5);
        result_ch.ready <= 0;
      end else begin
        result_ch.ready <= 1;
      end
    end
  end

  task send_word(logic rt, logic [7:0] b);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      item_ch.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    item_ch.valid <= 1;
    item_ch.req_type <= rt;
    item_ch.byte_value <= b;
    sb.note_input(rt, b);
    words_sent++;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task write_center(logic idx, logic [31:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_center(idx, v);
  endtask

  task drain();
    item_ch.valid <= 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // one instruction with random content; rarely cut short by a start
  task send_instruction();
    logic [2:0] op;
    int len;
    op = 3'($urandom_range(0, 7));
    if (op == OP_HALT && $urandom_range(0, 2) != 0) op = OP_STAT;
    len = (op == OP_VCTR) ? 4 : 2;
    if ($urandom_range(0, 40) == 0) begin
      send_word(REQ_START, 8'($urandom));
      return;
    end
    send_word(REQ_BYTE, {op, 5'($urandom)});
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(0, 60) == 0) begin
        send_word(REQ_START, 8'($urandom));
        return;
      end
      send_word(REQ_BYTE, 8'($urandom));
    end
    if (op == OP_HALT) begin
      repeat ($urandom_range(0, 2)) send_word(REQ_BYTE, 8'($urandom));
      send_word(REQ_START, 8'($urandom));
    end
  endtask

  initial begin
    logic [31:0] cx[4] = '{32'h0, 32'hffff_ffff, CENTER_RESET, 32'h0};
    logic [31:0] cy[4] = '{32'hffff_ffff, 32'h0, CENTER_RESET, 32'h0};
    rst <= 1;
    psel <= 0; penable <= 0; pwrite <= 0; paddr <= '0; pwdata <= '0;
    item_ch.valid <= 0; item_ch.req_type <= REQ_START; item_ch.byte_value <= '0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset centers, then each instruction and the corner cases
    send_word(REQ_BYTE, 8'h55);
    send_word(REQ_START, 8'h00);
    send_word(REQ_BYTE, {OP_STAT, 5'h0f}); send_word(REQ_BYTE, 8'hff);
    send_word(REQ_BYTE, {OP_STAT, 5'h17}); send_word(REQ_BYTE, 8'h00);
    send_word(REQ_BYTE, {OP_VCTR, 5'h1f}); send_word(REQ_BYTE, 8'hff);
    send_word(REQ_BYTE, 8'hff); send_word(REQ_BYTE, 8'hff);
    send_word(REQ_BYTE, {OP_VCTR, 5'h00}); send_word(REQ_BYTE, 8'h00);
    send_word(REQ_BYTE, 8'h00); send_word(REQ_BYTE, 8'h00);
    send_word(REQ_BYTE, {OP_SVEC, 5'h1f}); send_word(REQ_BYTE, 8'hff);
    send_word(REQ_BYTE, {OP_CNTR, 5'h00}); send_word(REQ_BYTE, 8'h00);
    send_word(REQ_BYTE, {OP_JSRL, 5'h1f}); send_word(REQ_BYTE, 8'hff);
    send_word(REQ_BYTE, {OP_RTSL, 5'h00}); send_word(REQ_BYTE, 8'h00);
    send_word(REQ_BYTE, {OP_JMPL, 5'h00}); send_word(REQ_BYTE, 8'h80);
    // start in mid instruction, then halt, ignored byte, restart
    send_word(REQ_BYTE, {OP_VCTR, 5'h03});
    send_word(REQ_START, 8'h00);
    send_word(REQ_BYTE, {OP_HALT, 5'h00}); send_word(REQ_BYTE, 8'h00);
    send_word(REQ_BYTE, 8'haa);
    send_word(REQ_START, 8'h00);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_center(REG_CENTER_X, ph == 3 ? $urandom : cx[ph]);
      write_center(REG_CENTER_Y, ph == 3 ? $urandom : cy[ph]);
      gaps_on = (ph != 3);
      send_word(REQ_START, 8'($urandom));
      while (words_sent < 25 + (ph + 1) * 360) send_instruction();
    end

    drain();
    if (sb.errors == 0)
      $display("vector_display_list_processor test passed");
    else
      $display("vector_display_list_processor test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("vector_display_list_processor test failed");
    $finish;
  end
endmodule
